// File: src/crtti_pkg.sv
// Shared types, constants and helpers for the custom-radix text-to-integer parser.
// No dependencies; used by crtti_cfg, crtti_lookup, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package crtti_pkg;

  localparam int SLOTS       = 16;  // symbol slots held by the two alphabet registers
  localparam int MAX_SYMBOLS = 16;  // longest alphabet accepted as valid

  localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [1:0] REG_ALPHA_LEN  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef logic [SLOTS-1:0][7:0] sym_arr_t;

  typedef struct packed {
    sym_arr_t   sym;
    logic [4:0] len;
    logic       ok;
  } alpha_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } digit_t;

  function automatic logic alphabet_ok(input sym_arr_t sym, input logic [4:0] len);
    logic ok;
    ok = (len >= 5'd2) && (len <= 5'(MAX_SYMBOLS));
    for (int a = 0; a < SLOTS; a++) begin
      if (5'(a) < len) begin
        if (sym[a] == CH_PLUS || sym[a] == CH_MINUS || sym[a] == CH_SPACE ||
            sym[a] == 8'd0) begin
          ok = 1'b0;
        end
        for (int b = a + 1; b < SLOTS; b++) begin
          if (5'(b) < len && sym[b] == sym[a]) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: src/crtti_cfg.sv
// Alphabet register file and registered alphabet validity flag.
// Depends on crtti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crtti_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  output crtti_pkg::alpha_t          alpha
);

  logic [63:0] low_r;
  logic [63:0] high_r;
  logic [4:0]  len_r;
  logic        ok_r;
  crtti_pkg::sym_arr_t sym;

  assign sym = {high_r, low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
      len_r  <= '0;
      ok_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          crtti_pkg::REG_ALPHA_LOW:  low_r  <= cfg_data;
          crtti_pkg::REG_ALPHA_HIGH: high_r <= cfg_data;
          crtti_pkg::REG_ALPHA_LEN:  len_r  <= cfg_data[4:0];
          default: ;
        endcase
      end
      // registered, so it trails a write; the input register covers that delay
      ok_r <= crtti_pkg::alphabet_ok(sym, len_r);
    end
  end

  assign alpha.sym = sym;
  assign alpha.len = len_r;
  assign alpha.ok  = ok_r;

endmodule

`default_nettype wire

// File: src/crtti_lookup.sv
// Parallel digit lookup: matches a character against the symbols in use.
// Depends on crtti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crtti_lookup (
  input  wire logic [7:0]        character,
  input  wire crtti_pkg::alpha_t alpha,
  output crtti_pkg::digit_t      digit
);

  always_comb begin
    digit = '0;
    // scan downward so the lowest matching slot wins
    for (int k = crtti_pkg::SLOTS - 1; k >= 0; k--) begin
      if (5'(k) < alpha.len && alpha.sym[k] == character) begin
        digit.hit   = 1'b1;
        digit.value = 4'(k);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/custom_radix_text_to_int_top.sv
// Top level of the custom-radix text-to-integer parser.
// Depends on crtti_pkg, crtti_cfg and crtti_lookup.
`timescale 1ns / 1ps
`default_nettype none

// One character is taken per cycle while input is not stalled. Each request
// enters an input register, from which the whitespace/sign/digit step and the
// accumulate (accumulator * radix + digit) run and update the parse state. The
// request marked tlast loads the result register, so its result shows on the
// out channel after the input register and the result register. The sustained
// rate of one character per cycle is set by the accumulate loop. Input is
// stalled only when a last request waits behind a result not yet taken.
// Configure the alphabet while no string is in flight.
module custom_radix_text_to_int_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // text in
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  input  wire logic        in_tlast,   // last character of the string
  // value out
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] value
  output      logic        out_tuser   // [0] alphabet_valid
);

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  crtti_pkg::alpha_t alpha;
  crtti_pkg::digit_t digit;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;

  logic [1:0]  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, result;
  logic        out_ok_r;

  logic        adv;
  logic        is_ws;
  logic [36:0] prod;

  assign cfg_ready = 1'b1;

  crtti_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alpha     (alpha)
  );

  crtti_lookup u_lookup (
    .character (s1_char_r),
    .alpha     (alpha),
    .digit     (digit)
  );

  // a last request may leave stage 1 only when the result slot frees up
  assign adv       = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign is_ws = (s1_char_r == crtti_pkg::CH_SPACE) ||
                 (s1_char_r >= crtti_pkg::CH_TAB && s1_char_r <= crtti_pkg::CH_CR);
  assign prod  = acc_r * {27'd0, alpha.len};

  always_comb begin
    logic [1:0] ph;
    logic       used;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ph        = phase_r;
    used      = 1'b0;
    if (ph == PH_SPACE) begin
      if (is_ws) begin
        used = 1'b1;
      end else begin
        ph = PH_SIGN;
      end
    end
    if (!used && ph == PH_SIGN) begin
      if (s1_char_r == crtti_pkg::CH_MINUS) begin
        neg_nxt = ~neg_r;
        used    = 1'b1;
      end else if (s1_char_r == crtti_pkg::CH_PLUS) begin
        used = 1'b1;
      end else begin
        ph = PH_DIGIT;
      end
    end
    if (!used && ph == PH_DIGIT) begin
      if (digit.hit) begin
        acc_nxt = prod[31:0] + {28'd0, digit.value};
      end else begin
        ph = PH_DONE;
      end
    end
    phase_nxt = ph;
  end

  assign result = !alpha.ok ? 32'd0 : (neg_nxt ? (32'd0 - acc_nxt) : acc_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        if (s1_last_r) begin
          phase_r <= PH_SPACE;
          neg_r   <= 1'b0;
          acc_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv && s1_last_r) begin
      out_value_r <= result;
      out_ok_r    <= alpha.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire

// File: src/crtti_checker.sv
// Port-level checks for custom_radix_text_to_int_top, bound to the top level.
// Sees only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module crtti_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_ready,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_bad_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("nonzero value with invalid alphabet");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind custom_radix_text_to_int_top crtti_checker u_crtti_checker (.*);

`default_nettype wire

// File: dv/tb_custom_radix_text_to_int_top.sv
// Testbench for custom_radix_text_to_int_top: streams text strings and checks each parsed value.
// Depends on crtti_pkg and the RTL under src/; self-checking, no external files.
`timescale 1ns / 1ps

module tb_custom_radix_text_to_int_top;

  localparam int QUIET_LIMIT = 3000;  // cycles with no request moving on any channel

  typedef enum logic [1:0] {SKIP_WS, SIGN_RUN, DIGITS, FROZEN} parse_phase_t;
  typedef enum int {FLAW_SHORT, FLAW_BAD_SYMBOL, FLAW_DUPLICATE} alpha_flaw_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = crtti_pkg::REG_ALPHA_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  custom_radix_text_to_int_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser mirror: alphabet copy plus parse state
  logic [127:0]  alpha_syms = '0;
  logic [4:0]    alpha_len = '0;
  parse_phase_t  phase_q = SKIP_WS;
  logic          neg_q = 1'b0;
  logic [31:0]   acc_q = '0;
  parse_result_t expected_q[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;
  int errors = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int alphabets_set = 0;
  int bad_alphabets = 0;
  int quiet_cycles = 0;

  task automatic parse_char(input logic [7:0] ch, input logic last);
    logic          used;
    logic          ok;
    logic [255:0]  seen;
    logic [7:0]    s;
    int            d;
    parse_result_t r;
    used = 1'b0;
    if (phase_q == SKIP_WS) begin
      if (ch == crtti_pkg::CH_SPACE || (ch >= crtti_pkg::CH_TAB && ch <= crtti_pkg::CH_CR))
        used = 1'b1;
      else phase_q = SIGN_RUN;
    end
    if (!used && phase_q == SIGN_RUN) begin
      if (ch == crtti_pkg::CH_MINUS) begin
        neg_q = ~neg_q;
        used = 1'b1;
      end else if (ch == crtti_pkg::CH_PLUS) begin
        used = 1'b1;
      end else begin
        phase_q = DIGITS;
      end
    end
    if (!used && phase_q == DIGITS) begin
      // scan downward so the lowest matching slot wins
      d = -1;
      for (int k = 15; k >= 0; k--)
        if (k < alpha_len && alpha_syms[8*k +: 8] == ch) d = k;
      if (d < 0) phase_q = FROZEN;
      else acc_q = acc_q * {27'd0, alpha_len} + 32'(d);
    end
    if (last) begin
      seen = '0;
      ok = (alpha_len >= 5'd2) && (alpha_len <= 5'(crtti_pkg::MAX_SYMBOLS));
      for (int k = 0; k < 16; k++) begin
        if (k < alpha_len) begin
          s = alpha_syms[8*k +: 8];
          if (s == 8'd0 || s == crtti_pkg::CH_PLUS || s == crtti_pkg::CH_MINUS ||
              s == crtti_pkg::CH_SPACE || seen[s]) ok = 1'b0;
          seen[s] = 1'b1;
        end
      end
      r.ok = ok;
      r.value = ok ? (neg_q ? 32'(32'd0 - acc_q) : acc_q) : 32'd0;
      expected_q.push_back(r);
      phase_q = SKIP_WS;
      neg_q = 1'b0;
      acc_q = '0;
      strings_sent++;
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    parse_char(ch, last);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  // wait out every pending result plus the pipeline, with input quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; set_alphabet lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crtti_pkg::REG_ALPHA_LOW:  alpha_syms[63:0] = data;
      crtti_pkg::REG_ALPHA_HIGH: alpha_syms[127:64] = data;
      crtti_pkg::REG_ALPHA_LEN:  alpha_len = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_alphabet(input logic [127:0] syms, input logic [4:0] len);
    // alphabet changes only with the parser empty
    settle();
    write_reg(crtti_pkg::REG_ALPHA_LOW, syms[63:0]);
    write_reg(crtti_pkg::REG_ALPHA_HIGH, syms[127:64]);
    write_reg(crtti_pkg::REG_ALPHA_LEN, {59'd0, len});
    cfg_valid <= 1'b0;
    alphabets_set++;
  endtask

  function automatic logic [127:0] pack_text(input string txt);
    logic [127:0] p;
    p = '0;
    for (int k = 0; k < txt.len() && k < 16; k++) p[8*k +: 8] = txt[k];
    return p;
  endfunction

  function automatic logic [7:0] some_digit();
    if (alpha_len == 5'd0) return 8'($urandom);
    return alpha_syms[8*$urandom_range(0, alpha_len - 1) +: 8];
  endfunction

  task automatic random_alphabet();
    logic [127:0] syms;
    logic [255:0] taken;
    logic [7:0]   b;
    logic [7:0]   banned [4];
    int           len;
    int           k;
    banned = '{8'd0, crtti_pkg::CH_PLUS, crtti_pkg::CH_MINUS, crtti_pkg::CH_SPACE};
    taken = '0;
    foreach (banned[i]) taken[banned[i]] = 1'b1;
    len = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(2, 16);
    for (int j = 0; j < 16; j++) begin
      if (j < len) begin
        do b = 8'($urandom_range(1, 255)); while (taken[b]);
        taken[b] = 1'b1;
      end else begin
        b = 8'($urandom);  // slots past the length are don't-care
      end
      syms[8*j +: 8] = b;
    end
    if ($urandom_range(0, 5) == 0) begin
      bad_alphabets++;
      case (alpha_flaw_t'($urandom_range(0, 2)))
        FLAW_SHORT:      len = $urandom_range(0, 1);
        FLAW_BAD_SYMBOL: syms[8*$urandom_range(0, len - 1) +: 8] = banned[$urandom_range(0, 3)];
        FLAW_DUPLICATE: begin
          k = $urandom_range(1, len - 1);
          syms[8*k +: 8] = syms[8*$urandom_range(0, k - 1) +: 8];
        end
        default: ;
      endcase
    end
    set_alphabet(syms, 5'(len));
  endtask

  task automatic send_random_string();
    logic [7:0] txt[$];
    int         kind;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3))
        txt.push_back($urandom_range(0, 1) ? crtti_pkg::CH_SPACE :
                      8'($urandom_range(crtti_pkg::CH_TAB, crtti_pkg::CH_CR)));
      repeat ($urandom_range(0, 3))
        txt.push_back($urandom_range(0, 1) ? crtti_pkg::CH_MINUS : crtti_pkg::CH_PLUS);
      repeat ($urandom_range(0, 12)) txt.push_back(some_digit());
      repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom));
      // broken form: a stray byte somewhere inside
      if (kind == 7 && txt.size() > 1) txt.insert($urandom_range(0, txt.size() - 1), 8'($urandom));
      if (txt.size() == 0) txt.push_back(some_digit());
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  // ---- tests ----

  task automatic test_reset_alphabet();
    send_text("5");  // empty alphabet after reset
    set_alphabet({128{1'b1}}, 5'd16);
    send_text("9");
    settle();
  endtask

  task automatic test_decimal_parse();
    set_alphabet(pack_text("0123456789"), 5'd10);
    send_text(" \t-+42");
    send_text("- 5");  // space after the sign run freezes at zero
    send_char("1", 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'hff, 1'b1);
    settle();
  endtask

  task automatic test_whitespace_symbol();
    logic [127:0] syms;
    syms = '0;
    syms[7:0] = crtti_pkg::CH_TAB;
    syms[15:8] = "a";
    set_alphabet(syms, 5'd2);
    // leading tab skipped, later tab is digit zero
    send_char(crtti_pkg::CH_TAB, 1'b0);
    send_char("a", 1'b0);
    send_char(crtti_pkg::CH_TAB, 1'b1);
    settle();
  endtask

  task automatic test_overflow();
    set_alphabet(pack_text("0123456789ABCDEF"), 5'd16);
    send_text("-FFFFFFFFF");
    settle();
  endtask

  task automatic test_invalid_alphabets();
    set_alphabet(pack_text("0"), 5'd1);
    send_text("0");
    set_alphabet(pack_text("01+3"), 5'd4);
    send_text("1");
    set_alphabet(pack_text("0120"), 5'd4);
    send_text("2");
    set_alphabet(pack_text("01"), 5'd3);
    send_text("1");
    settle();
  endtask

  task automatic test_backpressure();
    set_alphabet(pack_text("0123456789"), 5'd10);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 400;
    repeat (30) send_char(some_digit(), 1'b1);
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_strings(input int target);
    int left_in_phase;
    left_in_phase = 0;
    while (chars_sent < target) begin
      if (left_in_phase == 0) begin
        settle();
        random_alphabet();
        left_in_phase = $urandom_range(8, 30);
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      send_random_string();
      left_in_phase--;
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_alphabet();
    test_decimal_parse();
    test_whitespace_symbol();
    test_overflow();
    test_invalid_alphabets();
    test_backpressure();
    test_random_strings(1350);
    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d characters in %0d strings, %0d results compared.",
             chars_sent, strings_sent, results_seen);
    $display("Alphabet settings: %0d, of which %0d random ones were malformed.",
             alphabets_set, bad_alphabets);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold on request, compare against the queue
  initial begin : result_checker
    int            stall;
    parse_result_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 11) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d alphabet_valid %0b", $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.value) begin
          $error("value: expected %0d, actual %0d", $signed(want.value), $signed(out_tdata));
          errors++;
        end
        if (out_tuser !== want.ok) begin
          $error("alphabet_valid: expected %0b, actual %0b", want.ok, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles, %0d results pending",
               QUIET_LIMIT, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
